// File: src/set_assoc_cache_tag_store_core_macros.svh
// assertion macros for the tag store core
`ifndef SET_ASSOC_CACHE_TAG_STORE_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_STORE_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define SACTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tag store check failed");
// next-cycle implication
`define SACTS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tag store check failed");
`endif

// File: src/sacts_pkg.sv
// shared constants, types and helpers for the tag store
package sacts_pkg;
	localparam int unsigned SETS = 64;
	localparam int unsigned WAYS = 4;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ADDR_WIDTH = 32;
	localparam int unsigned OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int unsigned SET_BITS = $clog2(SETS + 1) - 1;
	localparam int unsigned SET_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int unsigned TAG_W = ADDR_WIDTH - OFF_BITS - SET_BITS;
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [1:0] POL_LRU = 2'd0;
	localparam logic [1:0] POL_LFU = 2'd1;
	localparam logic [1:0] POL_FIFO = 2'd2;
	localparam logic [1:0] POL_RAND = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

	// per-line record kept in the set memory
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] cnt;
	} line_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction
endpackage

// File: src/sacts_ctrl.sv
// controller: read cycle then write cycle, result register with handshake
module sacts_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output sacts_pkg::cmd_t cmd
);
	typedef enum logic {ST_READ, ST_WRITE} state_t;
	state_t state_q;
	logic out_valid_q;

	// accept in the read state; the write state holds the item while a result waits
	assign in_ready = (state_q == ST_READ);
	assign out_valid = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	// write back only once the result slot is empty or draining
	assign cmd.update = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READ;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_READ: begin
					if (out_valid_q && out_ready) out_valid_q <= 1'b0;
					if (cmd.capture) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (cmd.update) begin
						out_valid_q <= 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_READ;
			endcase
		end
	end
endmodule

// File: src/sacts_dp.sv
// datapath: set memory, valid bits, victim choice and counter update
module sacts_dp (
	input  logic clk,
	input  logic arst_n,
	input  sacts_pkg::cmd_t cmd,
	input  logic [1:0] policy,
	input  logic mode,
	input  logic [31:0] address,
	output logic hit,
	output logic evicted,
	output logic [1:0] way
);
	localparam int unsigned W = sacts_pkg::WAYS;
	localparam int unsigned WW = sacts_pkg::WAY_W;
	localparam int unsigned CW = sacts_pkg::CNT_W;
	localparam int unsigned TW = sacts_pkg::TAG_W;

	sacts_pkg::line_t mem_q [sacts_pkg::SETS][W];
	sacts_pkg::line_t rd_s1 [W];
	logic [W-1:0] valid_q [sacts_pkg::SETS];
	logic [W-1:0] vld_s1;
	logic [sacts_pkg::SET_W-1:0] set_s1;
	logic [TW-1:0] tag_s1;
	logic mode_s1;
	logic [15:0] lfsr_q;
	logic hit_q, evicted_q;
	logic [1:0] way_q;

	logic [sacts_pkg::ADDR_WIDTH-1:0] addr_m;
	logic [sacts_pkg::SET_W-1:0] set_c;
	logic [TW-1:0] tag_c;

	assign addr_m = sacts_pkg::ADDR_WIDTH'(address);
	assign tag_c = addr_m[sacts_pkg::ADDR_WIDTH-1 -: TW];
	generate
		if (sacts_pkg::SET_BITS > 0) begin : g_set
			assign set_c = addr_m[sacts_pkg::OFF_BITS +: sacts_pkg::SET_W];
		end else begin : g_noset
			assign set_c = '0;
		end
	endgenerate

	// read the set
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < W; i++) rd_s1[i] <= mem_q[set_c][i];
			set_s1 <= set_c;
			tag_s1 <= tag_c;
			mode_s1 <= mode;
		end
	end

	// valid bits of the selected set, registered with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= '0;
		else if (cmd.capture) vld_s1 <= valid_q[set_c];
	end

	// compare, choose and compute new counters
	logic found, free_found;
	logic [WW-1:0] hit_w, free_w, best_w, vic_w, tgt_w;
	logic [15:0] lfsr_n;
	logic [CW-1:0] mine;
	logic [CW-1:0] new_cnt [W];
	logic wr_en;

	always_comb begin
		found = 1'b0; hit_w = '0;
		free_found = 1'b0; free_w = '0;
		for (int i = W-1; i >= 0; i--) begin
			if (vld_s1[i] && rd_s1[i].tag == tag_s1) begin
				found = 1'b1; hit_w = WW'(i);
			end
			if (!vld_s1[i]) begin
				free_found = 1'b1; free_w = WW'(i);
			end
		end
		best_w = '0;
		for (int i = 1; i < W; i++) begin
			if (policy == sacts_pkg::POL_LFU) begin
				if (rd_s1[i].cnt < rd_s1[best_w].cnt) best_w = WW'(i);
			end else if (rd_s1[i].cnt > rd_s1[best_w].cnt) best_w = WW'(i);
		end
		lfsr_n = lfsr_q >> 1;
		if (lfsr_q[0]) lfsr_n = lfsr_n ^ sacts_pkg::LFSR_TAPS;
		if (policy == sacts_pkg::POL_RAND) vic_w = WW'(lfsr_n % 16'(W));
		else vic_w = best_w;
		tgt_w = found ? hit_w : (free_found ? free_w : vic_w);
		mine = rd_s1[hit_w].cnt;
		wr_en = 1'b0;
		for (int i = 0; i < W; i++) new_cnt[i] = rd_s1[i].cnt;
		if (!mode_s1) begin
			if (found && policy == sacts_pkg::POL_LRU) begin
				wr_en = 1'b1;
				for (int i = 0; i < W; i++)
					if (vld_s1[i] && rd_s1[i].cnt < mine)
						new_cnt[i] = sacts_pkg::sat_inc(rd_s1[i].cnt);
				new_cnt[hit_w] = '0;
			end else if (found && policy == sacts_pkg::POL_LFU) begin
				wr_en = 1'b1;
				new_cnt[hit_w] = sacts_pkg::sat_inc(mine);
			end
		end else begin
			wr_en = 1'b1;
			if (!found && (policy == sacts_pkg::POL_LRU || policy == sacts_pkg::POL_FIFO))
				for (int i = 0; i < W; i++)
					if (WW'(i) != tgt_w && vld_s1[i])
						new_cnt[i] = sacts_pkg::sat_inc(rd_s1[i].cnt);
			new_cnt[tgt_w] = '0;
		end
	end

	// write back the set
	always_ff @(posedge clk) begin
		if (cmd.update && wr_en) begin
			for (int i = 0; i < W; i++) begin
				mem_q[set_s1][i].cnt <= new_cnt[i];
				if (mode_s1 && !found && WW'(i) == tgt_w) mem_q[set_s1][i].tag <= tag_s1;
			end
		end
	end

	// valid bits, lfsr, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < sacts_pkg::SETS; s++) valid_q[s] <= '0;
			lfsr_q <= sacts_pkg::LFSR_SEED;
			hit_q <= 1'b0;
			evicted_q <= 1'b0;
			way_q <= '0;
		end else if (cmd.update) begin
			if (mode_s1 && !found) valid_q[set_s1][tgt_w] <= 1'b1;
			if (mode_s1 && !found && !free_found && policy == sacts_pkg::POL_RAND)
				lfsr_q <= lfsr_n;
			hit_q <= found;
			evicted_q <= mode_s1 && !found && !free_found;
			way_q <= (mode_s1 || found) ? 2'(tgt_w) : 2'd0;
		end
	end

	assign hit = hit_q;
	assign evicted = evicted_q;
	assign way = way_q;
endmodule

// File: src/set_assoc_cache_tag_store_core.sv
// flow: the set is read on the input transfer, then written back, and the result is registered with the write back
// a new input transfer is taken only after the write back of the last item (set memory read-modify-write);
// a waiting result holds the write back and with it the next input transfer
// reset: valid bits cleared at once, counters undefined until a line is filled,
// lfsr reseeded to 0xACE1, policy register to LRU; no clearing pass
module set_assoc_cache_tag_store_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [31:0] address,
	output logic out_valid,
	input  logic out_ready,
	output logic hit,
	output logic evicted,
	output logic [1:0] way,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata
);
`include "set_assoc_cache_tag_store_core_macros.svh"
	sacts_pkg::cmd_t cmd;
	logic [1:0] policy_q;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= sacts_pkg::POL_LRU;
		else if (cfg_we) policy_q <= cfg_wdata;
	end

	sacts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	sacts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .policy(policy_q), .mode(mode),
		.address(address), .hit(hit), .evicted(evicted), .way(way)
	);

	// checks
	`SACTS_ASSERT_IMP(a_upd_blocks_in, cmd.update, !in_ready)
	`SACTS_ASSERT_NXT(a_no_back2back, in_valid && in_ready, !in_ready)
	`SACTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`SACTS_ASSERT_IMP(a_evict_fill, out_valid && evicted, !hit)
endmodule
